@@ rtl/gzhs_pkg.sv @@
// shared phase codes, status codes, result type and section lookup for the gzip header stripper
package gzhs_pkg;

  // parser phase codes
  localparam logic [3:0] PH_MAGIC1  = 4'd0;
  localparam logic [3:0] PH_MAGIC2  = 4'd1;
  localparam logic [3:0] PH_METHOD  = 4'd2;
  localparam logic [3:0] PH_FLAGS   = 4'd3;
  localparam logic [3:0] PH_FIXED   = 4'd4;
  localparam logic [3:0] PH_XLEN_LO = 4'd5;
  localparam logic [3:0] PH_XLEN_HI = 4'd6;
  localparam logic [3:0] PH_EXTRA   = 4'd7;
  localparam logic [3:0] PH_NAME    = 4'd8;
  localparam logic [3:0] PH_COMMENT = 4'd9;
  localparam logic [3:0] PH_HCRC    = 4'd10;
  localparam logic [3:0] PH_BODY    = 4'd11;

  // per-item status codes
  localparam logic [2:0] ST_HEADER  = 3'd0;
  localparam logic [2:0] ST_PAYLOAD = 3'd1;
  localparam logic [2:0] ST_ERROR   = 3'd2;
  localparam logic [2:0] ST_DISCARD = 3'd3;
  localparam logic [2:0] ST_TRUNC   = 3'd4;

  // header constants
  localparam logic [7:0]  MAGIC1_BYTE   = 8'h1f;
  localparam logic [7:0]  MAGIC2_BYTE   = 8'h8b;
  localparam logic [7:0]  METHOD_BYTE   = 8'h08;
  localparam logic [7:0]  FLG_RSVD_MASK = 8'he0;
  localparam logic [15:0] FIXED_LEN     = 16'd6;
  localparam logic [15:0] HCRC_LEN      = 16'd2;

  // flag bit positions after dropping the text bit
  localparam int unsigned FL_HCRC    = 0;
  localparam int unsigned FL_EXTRA   = 1;
  localparam int unsigned FL_NAME    = 2;
  localparam int unsigned FL_COMMENT = 3;

  // result item handed to the output register
  typedef struct packed {
    logic [7:0] payload_byte;
    logic [2:0] status;
    logic       end_of_stream;
  } result_t;

  // first enabled optional section at or after a phase
  function automatic logic [3:0] next_section(input logic [3:0] from, input logic [3:0] flags);
    logic [3:0] nxt;
    nxt = PH_BODY;
    if (from <= PH_XLEN_LO && flags[FL_EXTRA]) begin
      nxt = PH_XLEN_LO;
    end else if (from <= PH_NAME && flags[FL_NAME]) begin
      nxt = PH_NAME;
    end else if (from <= PH_COMMENT && flags[FL_COMMENT]) begin
      nxt = PH_COMMENT;
    end else if (from <= PH_HCRC && flags[FL_HCRC]) begin
      nxt = PH_HCRC;
    end
    return nxt;
  endfunction

endpackage

@@ rtl/gzip_header_stripper_top.sv @@
// top level of the gzip header stripper: parser feeding a result register
// each accepted input item's result is captured in the output register
// throughput: one item per cycle while the consumer takes each result, else the single output register stalls input
// an item is taken while a finished result waits if that result is taken in the same cycle
// reset: mode returns to gzip parsing, parser returns to the first magic byte, output empties
module gzip_header_stripper_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] payload_byte_o,
  output logic [2:0] status_o,
  output logic       end_of_stream_o
);

  logic              take;
  gzhs_pkg::result_t cur_result;
  gzhs_pkg::result_t out_result;

  assign take = in_valid_i && in_ready_o;

  // per-byte classification
  gzhs_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .take_i      (take),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .result_o    (cur_result)
  );

  // result register toward the consumer
  gzhs_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_result_i  (cur_result),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_result_o (out_result)
  );

  assign payload_byte_o  = out_result.payload_byte;
  assign status_o        = out_result.status;
  assign end_of_stream_o = out_result.end_of_stream;

endmodule

@@ rtl/gzhs_parser.sv @@
// header parser: mode register, parse state and per-byte classification
module gzhs_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  input  logic                 take_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_byte_i,
  output gzhs_pkg::result_t    result_o
);

  logic        gzip_mode_q;
  logic [3:0]  phase_q, phase_d;
  logic [15:0] skip_q, skip_d;
  logic [7:0]  len_lo_q, len_lo_d;
  logic [3:0]  flags_q, flags_d;
  logic        method_ok_q, method_ok_d;
  logic        magic_ok_q, magic_ok_d;
  logic        err_seen_q, err_seen_d;

  logic [2:0]  status;
  logic        fmt_err;
  logic        enter_sec;
  logic [3:0]  sec_from;
  logic        cnt_done;
  logic [15:0] xlen;

  // run counter shared by the fixed, extra and crc skips
  assign cnt_done = (skip_q <= 16'd1);
  assign xlen     = {data_byte_i, len_lo_q};

  // next state and status for the byte on the input
  always_comb begin
    phase_d     = phase_q;
    skip_d      = skip_q;
    len_lo_d    = len_lo_q;
    flags_d     = flags_q;
    method_ok_d = method_ok_q;
    magic_ok_d  = magic_ok_q;
    err_seen_d  = err_seen_q;
    status      = gzhs_pkg::ST_HEADER;
    fmt_err     = 1'b0;
    enter_sec   = 1'b0;
    sec_from    = gzhs_pkg::PH_BODY;

    if (!gzip_mode_q) begin
      status = gzhs_pkg::ST_PAYLOAD;
    end else if (err_seen_q) begin
      status = gzhs_pkg::ST_DISCARD;
    end else begin
      case (phase_q)
        gzhs_pkg::PH_MAGIC1: begin
          magic_ok_d = (data_byte_i == gzhs_pkg::MAGIC1_BYTE);
          phase_d    = gzhs_pkg::PH_MAGIC2;
        end
        gzhs_pkg::PH_MAGIC2: begin
          if (!(magic_ok_q && data_byte_i == gzhs_pkg::MAGIC2_BYTE)) begin
            fmt_err = 1'b1;
          end else begin
            phase_d = gzhs_pkg::PH_METHOD;
          end
        end
        gzhs_pkg::PH_METHOD: begin
          method_ok_d = (data_byte_i == gzhs_pkg::METHOD_BYTE);
          phase_d     = gzhs_pkg::PH_FLAGS;
        end
        gzhs_pkg::PH_FLAGS: begin
          if (!method_ok_q || (data_byte_i & gzhs_pkg::FLG_RSVD_MASK) != 8'd0) begin
            fmt_err = 1'b1;
          end else begin
            flags_d = data_byte_i[4:1];
            skip_d  = gzhs_pkg::FIXED_LEN;
            phase_d = gzhs_pkg::PH_FIXED;
          end
        end
        gzhs_pkg::PH_FIXED: begin
          skip_d = cnt_done ? 16'd0 : skip_q - 16'd1;
          if (cnt_done) begin
            enter_sec = 1'b1;
            sec_from  = gzhs_pkg::PH_XLEN_LO;
          end
        end
        gzhs_pkg::PH_XLEN_LO: begin
          len_lo_d = data_byte_i;
          phase_d  = gzhs_pkg::PH_XLEN_HI;
        end
        gzhs_pkg::PH_XLEN_HI: begin
          skip_d = xlen;
          if (xlen == 16'd0) begin
            enter_sec = 1'b1;
            sec_from  = gzhs_pkg::PH_NAME;
          end else begin
            phase_d = gzhs_pkg::PH_EXTRA;
          end
        end
        gzhs_pkg::PH_EXTRA: begin
          skip_d = cnt_done ? 16'd0 : skip_q - 16'd1;
          if (cnt_done) begin
            enter_sec = 1'b1;
            sec_from  = gzhs_pkg::PH_NAME;
          end
        end
        gzhs_pkg::PH_NAME: begin
          if (data_byte_i == 8'd0) begin
            enter_sec = 1'b1;
            sec_from  = gzhs_pkg::PH_COMMENT;
          end
        end
        gzhs_pkg::PH_COMMENT: begin
          if (data_byte_i == 8'd0) begin
            enter_sec = 1'b1;
            sec_from  = gzhs_pkg::PH_HCRC;
          end
        end
        gzhs_pkg::PH_HCRC: begin
          skip_d = cnt_done ? 16'd0 : skip_q - 16'd1;
          if (cnt_done) begin
            phase_d = gzhs_pkg::PH_BODY;
          end
        end
        default: begin
          // body and unused codes pass bytes on
          status = gzhs_pkg::ST_PAYLOAD;
        end
      endcase

      // move into the next enabled section, loading the crc length there
      if (enter_sec) begin
        phase_d = gzhs_pkg::next_section(sec_from, flags_q);
        if (phase_d == gzhs_pkg::PH_HCRC) begin
          skip_d = gzhs_pkg::HCRC_LEN;
        end
      end

      // error and truncation marking
      if (fmt_err) begin
        status     = gzhs_pkg::ST_ERROR;
        err_seen_d = 1'b1;
      end else if (status == gzhs_pkg::ST_HEADER && last_byte_i &&
                   phase_d != gzhs_pkg::PH_BODY) begin
        status = gzhs_pkg::ST_TRUNC;
      end
    end

    // the last byte of a stream, in any phase, returns the parser to its start
    if (last_byte_i) begin
      phase_d     = gzhs_pkg::PH_MAGIC1;
      skip_d      = 16'd0;
      len_lo_d    = 8'd0;
      flags_d     = 4'd0;
      method_ok_d = 1'b0;
      magic_ok_d  = 1'b0;
      err_seen_d  = 1'b0;
    end
  end

  // result for the current byte
  assign result_o.payload_byte  = (status == gzhs_pkg::ST_PAYLOAD) ? data_byte_i : 8'd0;
  assign result_o.status        = status;
  assign result_o.end_of_stream = last_byte_i;

  // mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gzip_mode_q <= 1'b1;
    end else if (cfg_we_i) begin
      gzip_mode_q <= cfg_wdata_i;
    end
  end

  // parse state, advanced once per accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= gzhs_pkg::PH_MAGIC1;
      skip_q      <= 16'd0;
      len_lo_q    <= 8'd0;
      flags_q     <= 4'd0;
      method_ok_q <= 1'b0;
      magic_ok_q  <= 1'b0;
      err_seen_q  <= 1'b0;
    end else if (take_i) begin
      phase_q     <= phase_d;
      skip_q      <= skip_d;
      len_lo_q    <= len_lo_d;
      flags_q     <= flags_d;
      method_ok_q <= method_ok_d;
      magic_ok_q  <= magic_ok_d;
      err_seen_q  <= err_seen_d;
    end
  end

endmodule

@@ rtl/gzhs_out_reg.sv @@
// output register holding one result item, refilled in the cycle it is taken
module gzhs_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  gzhs_pkg::result_t in_result_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output gzhs_pkg::result_t out_result_o
);

  logic              valid_q;
  gzhs_pkg::result_t result_q;

  // free when empty or being drained this cycle
  assign in_ready_o = !valid_q || out_ready_i;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      result_q <= in_result_i;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_result_o = result_q;

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the gzip header stripper: random byte streams against a predictor
module tb_top;
  import gzhs_pkg::*;

  localparam logic MODE_RAW  = 1'b0;
  localparam logic MODE_GZIP = 1'b1;
  localparam int STALL_LIMIT = 4000;
  localparam int GZIP_FILL   = 450;
  localparam int RAW_FILL    = 70;
  localparam int unsigned SEND_IDLE [3] = '{25, 81, 0};
  localparam int unsigned RECV_IDLE [3] = '{81, 25, 0};
  // every optional section present, zero-length extra, header ends on the last byte
  localparam logic [7:0] FULL_HEADER [16] = '{8'h1f, 8'h8b, 8'h08, 8'h1f, 8'hff, 8'h00,
                                              8'hff, 8'h00, 8'hff, 8'h00, 8'h00, 8'h00,
                                              8'h00, 8'h00, 8'h12, 8'h34};

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } body_item_t;

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       cfg_we_i       = 1'b0;
  logic       cfg_wdata_i    = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic       in_ready_o;
  logic [7:0] data_byte_i    = 8'h00;
  logic       last_byte_i    = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i    = 1'b0;
  logic [7:0] payload_byte_o;
  logic [2:0] status_o;
  logic       end_of_stream_o;

  // stimulus and expectation stores
  body_item_t  body_bytes [$];
  result_t     marked_bytes [$];
  logic [7:0]  stream_buf [$];
  int          hdr_len;
  int unsigned send_idle_pct = SEND_IDLE[0];
  int unsigned recv_idle_pct = RECV_IDLE[0];
  logic        in_fire = 1'b0;
  int          mismatches = 0;
  int          stall_cycles = 0;

  // predictor state
  logic        gzip_on;
  logic [3:0]  cur_phase;
  logic [15:0] skip_left;
  logic [7:0]  xlen_low;
  logic [3:0]  hdr_flags;
  logic        method_ok;
  logic        magic1_ok;
  logic        in_error;

  gzip_header_stripper_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .payload_byte_o (payload_byte_o),
    .status_o       (status_o),
    .end_of_stream_o(end_of_stream_o)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // parser state back to the first magic byte
  function automatic void clear_parser();
    cur_phase = PH_MAGIC1;
    skip_left = '0;
    xlen_low  = '0;
    hdr_flags = '0;
    method_ok = 1'b0;
    magic1_ok = 1'b0;
    in_error  = 1'b0;
  endfunction

  // one counted byte, true when the run is over
  function automatic bit skip_tick();
    if (skip_left <= 16'd1) begin
      skip_left = '0;
      return 1'b1;
    end
    skip_left = skip_left - 16'd1;
    return 1'b0;
  endfunction

  // move to the first enabled optional section at or after a phase
  function automatic void enter_section(input logic [3:0] from);
    if (from <= PH_XLEN_LO && hdr_flags[FL_EXTRA]) begin
      cur_phase = PH_XLEN_LO;
    end else if (from <= PH_NAME && hdr_flags[FL_NAME]) begin
      cur_phase = PH_NAME;
    end else if (from <= PH_COMMENT && hdr_flags[FL_COMMENT]) begin
      cur_phase = PH_COMMENT;
    end else if (from <= PH_HCRC && hdr_flags[FL_HCRC]) begin
      cur_phase = PH_HCRC;
      skip_left = HCRC_LEN;
    end else begin
      cur_phase = PH_BODY;
    end
  endfunction

  // mark one accepted byte and queue the expected result
  function automatic void classify_byte(input logic [7:0] d, input logic last);
    result_t r;
    logic    bad;
    r.status = ST_HEADER;
    bad = 1'b0;
    if (!gzip_on) begin
      r.status = ST_PAYLOAD;
    end else if (in_error) begin
      r.status = ST_DISCARD;
    end else begin
      case (cur_phase)
        PH_MAGIC1: begin
          magic1_ok = (d == MAGIC1_BYTE);
          cur_phase = PH_MAGIC2;
        end
        PH_MAGIC2: begin
          if (magic1_ok && d == MAGIC2_BYTE) cur_phase = PH_METHOD;
          else bad = 1'b1;
        end
        PH_METHOD: begin
          method_ok = (d == METHOD_BYTE);
          cur_phase = PH_FLAGS;
        end
        PH_FLAGS: begin
          if (!method_ok || (d & FLG_RSVD_MASK) != 8'h00) begin
            bad = 1'b1;
          end else begin
            hdr_flags = d[4:1];
            skip_left = FIXED_LEN;
            cur_phase = PH_FIXED;
          end
        end
        PH_FIXED: begin
          if (skip_tick()) enter_section(PH_XLEN_LO);
        end
        PH_XLEN_LO: begin
          xlen_low  = d;
          cur_phase = PH_XLEN_HI;
        end
        PH_XLEN_HI: begin
          skip_left = {d, xlen_low};
          if (skip_left == 16'd0) enter_section(PH_NAME);
          else cur_phase = PH_EXTRA;
        end
        PH_EXTRA: begin
          if (skip_tick()) enter_section(PH_NAME);
        end
        PH_NAME: begin
          if (d == 8'h00) enter_section(PH_COMMENT);
        end
        PH_COMMENT: begin
          if (d == 8'h00) enter_section(PH_HCRC);
        end
        PH_HCRC: begin
          if (skip_tick()) cur_phase = PH_BODY;
        end
        default: begin
          r.status = ST_PAYLOAD;
        end
      endcase
      if (bad) begin
        r.status = ST_ERROR;
        in_error = 1'b1;
      end else if (r.status == ST_HEADER && last && cur_phase != PH_BODY) begin
        r.status = ST_TRUNC;
      end
    end
    if (last) clear_parser();
    r.payload_byte  = (r.status == ST_PAYLOAD) ? d : 8'h00;
    r.end_of_stream = last;
    marked_bytes.push_back(r);
  endfunction

  // sender: next item at the falling edge once the current one is taken
  always @(negedge clk_i) begin : driver
    body_item_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_fire) begin
      if (body_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = body_bytes.pop_front();
        in_valid_i  <= 1'b1;
        data_byte_i <= nxt.data;
        last_byte_i <= nxt.last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stalls
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor: config tracking, result checks, prediction and watchdog
  always @(posedge clk_i) begin : monitor
    result_t want;
    if (!rst_ni) begin
      in_fire <= 1'b0;
    end else begin
      if (cfg_we_i) gzip_on = cfg_wdata_i;
      if (out_valid_o && out_ready_i) begin
        if (marked_bytes.size() == 0) begin
          $display("%0t: unexpected result: status %0d byte %02h eos %0b", $time,
                   status_o, payload_byte_o, end_of_stream_o);
          mismatches++;
        end else begin
          want = marked_bytes.pop_front();
          if (status_o !== want.status) begin
            $display("%0t: status mismatch: expected %0d got %0d", $time,
                     want.status, status_o);
            mismatches++;
          end
          if (payload_byte_o !== want.payload_byte) begin
            $display("%0t: payload byte mismatch: expected %02h got %02h", $time,
                     want.payload_byte, payload_byte_o);
            mismatches++;
          end
          if (end_of_stream_o !== want.end_of_stream) begin
            $display("%0t: end of stream mismatch: expected %0b got %0b", $time,
                     want.end_of_stream, end_of_stream_o);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_o) classify_byte(data_byte_i, last_byte_i);
      in_fire <= in_valid_i && in_ready_o;
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic push_byte(input logic [7:0] d, input logic last);
    body_bytes.push_back({d, last});
  endtask

  // waits until every queued item is sent and every result is back
  task automatic wait_drained();
    do @(posedge clk_i); while (body_bytes.size() != 0 || in_valid_i);
    @(negedge clk_i);
    while (marked_bytes.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // mode register write while the block is idle
  task automatic write_mode(input logic mode);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  // well-formed member with random flags, sections and payload
  task automatic build_member();
    logic [4:0] flg;
    int         xlen;
    int         n;
    stream_buf.delete();
    flg = 5'($urandom_range(31));
    stream_buf.push_back(MAGIC1_BYTE);
    stream_buf.push_back(MAGIC2_BYTE);
    stream_buf.push_back(METHOD_BYTE);
    stream_buf.push_back({3'b000, flg});
    repeat (6) stream_buf.push_back(8'($urandom_range(255)));
    // extra field, now and then long enough to use the high length byte
    if (flg[2]) begin
      if ($urandom_range(39) == 0) xlen = $urandom_range(256, 300);
      else xlen = $urandom_range(0, 6);
      stream_buf.push_back(xlen[7:0]);
      stream_buf.push_back(xlen[15:8]);
      repeat (xlen) stream_buf.push_back(8'($urandom_range(255)));
    end
    // name and comment strings
    if (flg[3]) begin
      n = $urandom_range(0, 5);
      repeat (n) stream_buf.push_back(8'($urandom_range(1, 255)));
      stream_buf.push_back(8'h00);
    end
    if (flg[4]) begin
      n = $urandom_range(0, 5);
      repeat (n) stream_buf.push_back(8'($urandom_range(1, 255)));
      stream_buf.push_back(8'h00);
    end
    if (flg[1]) repeat (2) stream_buf.push_back(8'($urandom_range(255)));
    hdr_len = stream_buf.size();
    n = $urandom_range(0, 10);
    repeat (n) stream_buf.push_back(8'($urandom_range(255)));
  endtask

  // member, mostly intact, sometimes broken or replaced by noise
  task automatic queue_member();
    int         pick;
    int         cut;
    logic [7:0] v;
    build_member();
    pick = $urandom_range(99);
    v = 8'($urandom_range(255));
    if (pick < 70) begin
      // intact
    end else if (pick < 75) begin
      stream_buf[0] = (v == MAGIC1_BYTE) ? ~v : v;
    end else if (pick < 80) begin
      stream_buf[1] = (v == MAGIC2_BYTE) ? ~v : v;
    end else if (pick < 84) begin
      stream_buf[2] = (v == METHOD_BYTE) ? ~v : v;
    end else if (pick < 88) begin
      stream_buf[3] = stream_buf[3] | {3'($urandom_range(1, 7)), 5'b00000};
    end else if (pick < 96) begin
      cut = $urandom_range(1, hdr_len - 1);
      while (stream_buf.size() > cut) void'(stream_buf.pop_back());
    end else begin
      stream_buf.delete();
      repeat ($urandom_range(1, 16)) stream_buf.push_back(8'($urandom_range(255)));
    end
    foreach (stream_buf[i]) push_byte(stream_buf[i], i == stream_buf.size() - 1);
  endtask

  // header interrupted by raw bytes, then finished in gzip mode
  task automatic split_member_across_modes();
    int cut;
    build_member();
    cut = $urandom_range(1, hdr_len - 1);
    for (int i = 0; i < cut; i++) push_byte(stream_buf[i], 1'b0);
    wait_drained();
    write_mode(MODE_RAW);
    repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(255)), 1'b0);
    wait_drained();
    write_mode(MODE_GZIP);
    for (int i = cut; i < stream_buf.size(); i++) begin
      push_byte(stream_buf[i], i == stream_buf.size() - 1);
    end
  endtask

  // reset, directed items, then random rounds under three stall profiles
  initial begin : stimulus
    gzip_on = MODE_GZIP;
    clear_parser();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_mode(MODE_GZIP);

    foreach (FULL_HEADER[i]) push_byte(FULL_HEADER[i], i == 15);
    // bad magic
    push_byte(8'h00, 1'b0);
    push_byte(MAGIC2_BYTE, 1'b1);
    // bad method and reserved flags, then a discarded byte
    push_byte(MAGIC1_BYTE, 1'b0);
    push_byte(MAGIC2_BYTE, 1'b0);
    push_byte(8'h07, 1'b0);
    push_byte(8'h20, 1'b0);
    push_byte(8'hff, 1'b1);
    // stream ends on the first byte
    push_byte(MAGIC1_BYTE, 1'b1);
    wait_drained();
    write_mode(MODE_RAW);
    push_byte(8'hff, 1'b0);
    push_byte(8'h00, 1'b1);
    wait_drained();
    write_mode(MODE_GZIP);

    for (int round = 0; round < 3; round++) begin
      send_idle_pct = SEND_IDLE[round];
      recv_idle_pct = RECV_IDLE[round];
      while (body_bytes.size() < GZIP_FILL) queue_member();
      wait_drained();
      split_member_across_modes();
      wait_drained();
      write_mode(MODE_RAW);
      repeat (RAW_FILL) push_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
      wait_drained();
      write_mode(MODE_GZIP);
    end

    wait_drained();
    repeat (5) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
